FILE: hw/rtl/srsf_pkg.sv
// Shared types and constants for the symmetric row smoothing filter.
// Used by the channel interfaces, the window cell, the tap lane and the top level.
package srsf_pkg;

    // Default sizing of the filter.
    localparam int DEF_MAX_TAPS       = 7;
    localparam int DEF_PIXEL_BITS     = 16;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // Configuration port and register widths.
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 17;
    localparam int COEF_W      = 17;
    localparam int TAP_COUNT_W = 3;
    localparam int NUM_COEF    = 7;

    // Reset values of the registers.
    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET   = 3'd1;
    localparam logic [COEF_W-1:0]      COEF_CENTER_RESET = 17'h10000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TAP_COUNT   = 4'd0,
        REG_COEF_CENTER = 4'd1,
        REG_COEF_OFF1   = 4'd2,
        REG_COEF_OFF2   = 4'd3,
        REG_COEF_OFF3   = 4'd4,
        REG_COEF_OFF4   = 4'd5,
        REG_COEF_OFF5   = 4'd6,
        REG_COEF_OFF6   = 4'd7
    } cfg_reg_t;

    // Controls of one window cell.
    typedef struct packed {
        logic shift;
        logic fill;
    } cell_ctrl_t;

    // Load enables of one tap lane, one per pipeline stage it owns.
    typedef struct packed {
        logic ld_pair;
        logic ld_prod;
    } lane_ctrl_t;

endpackage

FILE: hw/rtl/srsf_if.sv
// Channel interfaces of the symmetric row smoothing filter: input pixels,
// filtered pixels and register writes. Depends on srsf_pkg.

interface srsf_in_if #(
    parameter int PIXEL_BITS = srsf_pkg::DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;
    logic                  row_end;

    modport source (output valid, pixel_in, row_end, input ready);
    modport sink   (input valid, pixel_in, row_end, output ready);
endinterface

interface srsf_out_if #(
    parameter int PIXEL_BITS = srsf_pkg::DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  row_done;

    modport source (output valid, pixel_out, row_done, input ready);
    modport sink   (input valid, pixel_out, row_done, output ready);
endinterface

interface srsf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [srsf_pkg::CFG_ADDR_W-1:0]   index;
    logic [srsf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/symmetric_row_smoothing_filter_top.sv
// Top level of the symmetric row smoothing filter: window cells, tap lanes,
// adder stages and the row sequencer. Depends on srsf_pkg, srsf_if, srsf_cell, srsf_term.
//
// Usage. Pixels of one row enter on in_ch, one word per accepted handshake,
// with row_end set on the last pixel of the row. Each filtered pixel leaves
// on out_ch; row_done is set on the last filtered word of the row. Registers
// are written on cfg_ch (index 0 tap count, 1 center coefficient, 2 to 7 the
// offset coefficients), which is always ready; writes go in between rows or
// while the block is empty.
// Throughput: one pixel per cycle while out_ch accepts words. After a row_end
// pixel the block shifts the last pixel in again for the right border, once
// per active tap beyond the first, and in_ch.ready stays low during those shifts.
// The word for position x is built from the pixel at x+tap_count-1 (or the
// matching border shift) through the pair adders, the multipliers, the group
// adders and the final sum with saturation into the output register, each registered.
// Reset clears the sequencer, all stage valid flags and the registers to
// tap count 1, center coefficient 1.0 and offset coefficients 0.
// When the receiver stalls, words pile up in the pipeline stages, whose
// bubbles still fill, so input is taken until every stage holds a word.
module symmetric_row_smoothing_filter_top #(
    parameter int MAX_TAPS       = srsf_pkg::DEF_MAX_TAPS,
    parameter int PIXEL_BITS     = srsf_pkg::DEF_PIXEL_BITS,
    parameter int COEF_FRAC_BITS = srsf_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    srsf_in_if.sink      in_ch,
    srsf_out_if.source   out_ch,
    srsf_cfg_if.sink     cfg_ch
);

    localparam int WIN_DEPTH = 2 * MAX_TAPS - 1;
    localparam int TAPS_W    = $clog2(MAX_TAPS + 1);
    localparam int TERM_W    = PIXEL_BITS + 1 + srsf_pkg::COEF_W - COEF_FRAC_BITS;
    localparam int GROUP     = 4;
    localparam int NGROUP    = (MAX_TAPS + GROUP - 1) / GROUP;
    localparam int SUM_RAW_W = TERM_W + $clog2(MAX_TAPS) + 1;
    localparam int SUM_W     = (SUM_RAW_W > PIXEL_BITS) ? SUM_RAW_W : PIXEL_BITS + 1;

    // Configuration registers.
    logic [srsf_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    logic [srsf_pkg::COEF_W-1:0]      coef_reg [srsf_pkg::NUM_COEF];
    logic [2:0]                       coef_sel;

    assign cfg_ch.ready = 1'b1;
    assign coef_sel     = 3'(cfg_ch.index - srsf_pkg::REG_COEF_CENTER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= srsf_pkg::TAP_COUNT_RESET;
            coef_reg[0]   <= srsf_pkg::COEF_CENTER_RESET;
            for (int i = 1; i < srsf_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            if (cfg_ch.index == srsf_pkg::REG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_ch.data[srsf_pkg::TAP_COUNT_W-1:0];
            end
            else if (cfg_ch.index inside {[srsf_pkg::REG_COEF_CENTER:srsf_pkg::REG_COEF_OFF6]})
            begin
                coef_reg[coef_sel] <= cfg_ch.data[srsf_pkg::COEF_W-1:0];
            end
        end
    end

    // Active tap count: a zero count acts as one, and the count is capped at
    // the window's capacity.
    logic [TAPS_W-1:0] taps;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = TAPS_W'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            taps = TAPS_W'(MAX_TAPS);
        end
        else
        begin
            taps = TAPS_W'(tap_count_reg);
        end
    end

    // Pipeline handshake. Stage 0 is the window itself; it holds a pending
    // word when the last shift produced an output position.
    logic s0_valid_reg, s0_valid_next, s0_last_reg, s0_last_next;
    logic s1_valid_reg, s1_valid_next, s1_last_reg;
    logic s2_valid_reg, s2_valid_next, s2_last_reg;
    logic s3_valid_reg, s3_valid_next, s3_last_reg;
    logic out_valid_reg, out_valid_next, out_done_reg;
    logic ld1, ld2, ld3, ld4, shift_ok;

    assign ld4      = s3_valid_reg && (!out_valid_reg || out_ch.ready);
    assign ld3      = s2_valid_reg && (!s3_valid_reg || ld4);
    assign ld2      = s1_valid_reg && (!s2_valid_reg || ld3);
    assign ld1      = s0_valid_reg && (!s1_valid_reg || ld2);
    assign shift_ok = !s0_valid_reg || ld1;

    // Row sequencer: normal pixel intake, then the border flush after row_end.
    logic              started_reg, started_next;
    logic              flushing_reg, flushing_next;
    logic [TAPS_W-1:0] flush_cnt_reg, flush_cnt_next;
    logic [TAPS_W-1:0] fill_reg, fill_next;
    logic [TAPS_W-1:0] fill_new;
    logic              in_fire, flush_fire, shift_ev, emit;

    assign in_ch.ready = !flushing_reg && shift_ok;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign flush_fire  = flushing_reg && shift_ok;
    assign shift_ev    = in_fire || flush_fire;

    always_comb
    begin
        // Fill count saturates; the first pixel of a row starts it at one.
        if (in_fire && !started_reg)
        begin
            fill_new = TAPS_W'(1);
        end
        else if (fill_reg == TAPS_W'(MAX_TAPS))
        begin
            fill_new = fill_reg;
        end
        else
        begin
            fill_new = fill_reg + TAPS_W'(1);
        end
        emit = (fill_new >= taps);

        started_next   = started_reg;
        flushing_next  = flushing_reg;
        flush_cnt_next = flush_cnt_reg;
        fill_next      = fill_reg;
        s0_last_next   = s0_last_reg;
        s0_valid_next  = ld1 ? 1'b0 : s0_valid_reg;

        if (in_fire)
        begin
            s0_valid_next = emit;
            fill_next     = fill_new;
            started_next  = 1'b1;
            s0_last_next  = in_ch.row_end && (taps == TAPS_W'(1));
            if (in_ch.row_end)
            begin
                if (taps == TAPS_W'(1))
                begin
                    // A single tap needs no border shifts: the row ends here.
                    started_next = 1'b0;
                    fill_next    = '0;
                end
                else
                begin
                    flushing_next  = 1'b1;
                    flush_cnt_next = taps - TAPS_W'(1);
                end
            end
        end
        else if (flush_fire)
        begin
            // The final border shift always yields the row's last word.
            s0_valid_next  = emit;
            fill_next      = fill_new;
            s0_last_next   = (flush_cnt_reg == TAPS_W'(1));
            flush_cnt_next = flush_cnt_reg - TAPS_W'(1);
            if (flush_cnt_reg == TAPS_W'(1))
            begin
                flushing_next = 1'b0;
                started_next  = 1'b0;
                fill_next     = '0;
            end
        end
    end

    // Window: a chain of cells, newest sample in cell 0. During the flush
    // cell 0 keeps its own sample, which replicates the row's last pixel.
    logic [WIN_DEPTH-1:0][PIXEL_BITS-1:0] window;
    logic [PIXEL_BITS-1:0]                head_sample;
    srsf_pkg::cell_ctrl_t                 cell_ctrl;

    assign head_sample     = flushing_reg ? window[0] : in_ch.pixel_in;
    assign cell_ctrl.shift = shift_ev;
    assign cell_ctrl.fill  = in_fire && !started_reg;

    for (genvar w = 0; w < WIN_DEPTH; w++)
    begin : g_cell
        if (w == 0)
        begin : g_head
            srsf_cell #(
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .fill_value  (in_ch.pixel_in),
                .prev_sample (head_sample),
                .sample      (window[w])
            );
        end
        else
        begin : g_body
            srsf_cell #(
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .fill_value  (in_ch.pixel_in),
                .prev_sample (window[w-1]),
                .sample      (window[w])
            );
        end
    end

    // Tap lanes: stage 1 holds the pair sums, stage 2 the truncated products.
    logic [MAX_TAPS-1:0][TERM_W-1:0] terms;
    srsf_pkg::lane_ctrl_t            lane_ctrl;

    assign lane_ctrl.ld_pair = ld1;
    assign lane_ctrl.ld_prod = ld2;

    for (genvar t = 0; t < MAX_TAPS; t++)
    begin : g_lane
        logic [srsf_pkg::COEF_W-1:0] lane_coef;

        if (t < srsf_pkg::NUM_COEF)
        begin : g_coef
            assign lane_coef = coef_reg[t];
        end
        else
        begin : g_nocoef
            assign lane_coef = '0;
        end

        srsf_term #(
            .LANE           (t),
            .MAX_TAPS       (MAX_TAPS),
            .PIXEL_BITS     (PIXEL_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS),
            .WIN_DEPTH      (WIN_DEPTH),
            .TAPS_W         (TAPS_W),
            .TERM_W         (TERM_W)
        ) u_term (
            .clk    (clk),
            .ctrl   (lane_ctrl),
            .window (window),
            .taps   (taps),
            .coef   (lane_coef),
            .term   (terms[t])
        );
    end

    // Stage 3 adds the terms in groups of four; stage 4 adds the groups and
    // saturates to the pixel range.
    logic [SUM_W-1:0] grp_reg  [NGROUP];
    logic [SUM_W-1:0] grp_next [NGROUP];
    logic [SUM_W-1:0] total;
    logic [PIXEL_BITS-1:0] out_pixel_reg, out_pixel_next;

    always_comb
    begin
        int idx;
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                idx = (g * GROUP + j < MAX_TAPS) ? (g * GROUP + j) : 0;
                if (g * GROUP + j < MAX_TAPS)
                begin
                    grp_next[g] = grp_next[g] + SUM_W'(terms[idx]);
                end
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            total = total + grp_reg[g];
        end
        if (|total[SUM_W-1:PIXEL_BITS])
        begin
            out_pixel_next = '1;
        end
        else
        begin
            out_pixel_next = total[PIXEL_BITS-1:0];
        end
    end

    always_comb
    begin
        s1_valid_next  = ld1 ? 1'b1 : (ld2 ? 1'b0 : s1_valid_reg);
        s2_valid_next  = ld2 ? 1'b1 : (ld3 ? 1'b0 : s2_valid_reg);
        s3_valid_next  = ld3 ? 1'b1 : (ld4 ? 1'b0 : s3_valid_reg);
        out_valid_next = ld4 ? 1'b1 : ((out_valid_reg && out_ch.ready) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            flushing_reg  <= 1'b0;
            flush_cnt_reg <= '0;
            fill_reg      <= '0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            flushing_reg  <= flushing_next;
            flush_cnt_reg <= flush_cnt_next;
            fill_reg      <= fill_next;
            s0_valid_reg  <= s0_valid_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers follow their stage's load enable.
    always_ff @(posedge clk)
    begin
        s0_last_reg <= s0_last_next;
        if (ld1)
        begin
            s1_last_reg <= s0_last_reg;
        end
        if (ld2)
        begin
            s2_last_reg <= s1_last_reg;
        end
        if (ld3)
        begin
            s3_last_reg <= s2_last_reg;
            for (int g = 0; g < NGROUP; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
        if (ld4)
        begin
            out_done_reg  <= s3_last_reg;
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel_out = out_pixel_reg;
    assign out_ch.row_done  = out_done_reg;

endmodule

FILE: hw/rtl/srsf_cell.sv
// One sample cell of the filter's sliding window.
// Depends on srsf_pkg for the control struct.
module srsf_cell #(
    parameter int PIXEL_BITS = srsf_pkg::DEF_PIXEL_BITS
) (
    input  logic                   clk,
    input  srsf_pkg::cell_ctrl_t   ctrl,
    input  logic [PIXEL_BITS-1:0]  fill_value,
    input  logic [PIXEL_BITS-1:0]  prev_sample,
    output logic [PIXEL_BITS-1:0]  sample
);

    logic [PIXEL_BITS-1:0] sample_reg;
    logic [PIXEL_BITS-1:0] sample_next;

    // A row start loads every cell with the first pixel; otherwise the
    // cell takes its neighbor's sample on each window shift.
    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.fill)
        begin
            sample_next = fill_value;
        end
        else if (ctrl.shift)
        begin
            sample_next = prev_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign sample = sample_reg;

endmodule

FILE: hw/rtl/srsf_term.sv
// One tap lane: picks the sample pair for its offset around the window
// center, then multiplies by its coefficient and drops the fraction bits.
// Depends on srsf_pkg.
module srsf_term #(
    parameter int LANE           = 0,
    parameter int MAX_TAPS       = srsf_pkg::DEF_MAX_TAPS,
    parameter int PIXEL_BITS     = srsf_pkg::DEF_PIXEL_BITS,
    parameter int COEF_FRAC_BITS = srsf_pkg::DEF_COEF_FRAC_BITS,
    parameter int WIN_DEPTH      = 2 * MAX_TAPS - 1,
    parameter int TAPS_W         = $clog2(MAX_TAPS + 1),
    parameter int TERM_W         = PIXEL_BITS + 1 + srsf_pkg::COEF_W - COEF_FRAC_BITS
) (
    input  logic                                   clk,
    input  srsf_pkg::lane_ctrl_t                   ctrl,
    input  logic [WIN_DEPTH-1:0][PIXEL_BITS-1:0]   window,
    input  logic [TAPS_W-1:0]                      taps,
    input  logic [srsf_pkg::COEF_W-1:0]            coef,
    output logic [TERM_W-1:0]                      term
);

    localparam int PAIR_W = PIXEL_BITS + 1;
    localparam int PROD_W = PAIR_W + srsf_pkg::COEF_W;

    logic [PAIR_W-1:0] pair_reg;
    logic [PAIR_W-1:0] pair_next;
    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] term_next;
    logic [PROD_W-1:0] prod;

    // The window center sits at taps-1. A lane beyond the active tap count
    // contributes nothing; the center lane uses its sample once.
    always_comb
    begin
        int lo;
        int hi;
        pair_next = '0;
        for (int k = 1; k <= MAX_TAPS; k++)
        begin
            lo = (k > LANE) ? (k - 1 - LANE) : 0;
            hi = (k > LANE) ? (k - 1 + LANE) : 0;
            if ((k > LANE) && (taps == TAPS_W'(k)))
            begin
                if (LANE == 0)
                begin
                    pair_next = {1'b0, window[lo]};
                end
                else
                begin
                    pair_next = {1'b0, window[lo]} + {1'b0, window[hi]};
                end
            end
        end
    end

    assign prod      = PROD_W'(pair_reg) * PROD_W'(coef);
    assign term_next = prod[PROD_W-1:COEF_FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_pair)
        begin
            pair_reg <= pair_next;
        end
        if (ctrl.ld_prod)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule
